// ===== rtl/core/bps_pkg.sv =====
// Package for the battery power supervisor: shared types, codes and reset values.
// No dependencies; bps_button, bps_regread and battery_power_supervisor import it.
`timescale 1ns / 1ps
`default_nettype none

package bps_pkg;

    // Request codes carried in req_type
    typedef enum logic [2:0] {
        REQ_MS    = 3'd0,
        REQ_SLOW  = 3'd1,
        REQ_ADC   = 3'd2,
        REQ_WAKE  = 3'd3,
        REQ_START = 3'd4,
        REQ_DATA  = 3'd5
    } t_req;

    // Power modes
    typedef enum logic [1:0] {
        MODE_OFF = 2'd0,
        MODE_SYS = 2'd1,
        MODE_ON  = 2'd2
    } t_mode;

    // Button debounce phases; the unused code behaves like linger
    typedef enum logic [1:0] {
        PH_UP     = 2'd0,
        PH_DOWN   = 2'd1,
        PH_LINGER = 2'd2
    } t_phase;

    // Configuration register indexes
    localparam logic [1:0] CFG_SHORT_LIMIT = 2'd0;
    localparam logic [1:0] CFG_HOLD_LIMIT  = 2'd1;
    localparam logic [1:0] CFG_SD_DELAY    = 2'd2;
    localparam logic [1:0] CFG_SLEEP_TMO   = 2'd3;

    // Bus register map
    localparam logic [7:0] REG_MODE     = 8'd0;
    localparam logic [7:0] REG_SHUTDOWN = 8'd1;
    localparam logic [7:0] REG_LAST     = 8'd2;
    localparam logic [7:0] REG_CUTOFF   = 8'd3;
    localparam logic [7:0] REG_SLEEP    = 8'd4;
    localparam logic [7:0] REG_SHIST    = 8'd5;

    // Reset values and the press counter limit
    localparam logic [15:0] RST_SHORT_LIMIT = 16'd1000;
    localparam logic [15:0] RST_HOLD_LIMIT  = 16'd6000;
    localparam logic [7:0]  RST_SD_DELAY    = 8'd60;
    localparam logic [3:0]  RST_SLEEP_TMO   = 4'd15;
    localparam logic [9:0]  RST_CUTOFF      = 10'd492;
    localparam logic [15:0] PRESS_MAX       = 16'hffff;

    // Button state into the debounce logic
    typedef struct packed {
        logic [7:0]  hist;
        t_phase      phase;
        logic [15:0] press;
    } t_btn_state;

    // Button next state and its effect on power control
    typedef struct packed {
        logic [7:0]  hist;
        t_phase      phase;
        logic [15:0] press;
        t_mode       mode;
        logic [7:0]  shutdown;
        logic        reload_sleep;
    } t_btn_next;

    // Registers visible to bus reads
    typedef struct packed {
        t_mode      mode;
        logic [7:0] shutdown;
        logic [9:0] last_sample;
        logic [9:0] cutoff;
        logic [3:0] sleep;
        logic [7:0] shist;
    } t_reg_view;

endpackage

`default_nettype wire

// ===== rtl/core/bps_in_if.sv =====
// Input channel of the battery power supervisor: valid, ready and one request word.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface bps_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] req_type;
    logic       button_level;
    logic [9:0] adc_value;
    logic       bus_read;
    logic [7:0] bus_byte;

    modport source (output valid, req_type, button_level, adc_value, bus_read, bus_byte,
                    input ready);
    modport sink (input valid, req_type, button_level, adc_value, bus_read, bus_byte,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bps_out_if.sv =====
// Result channel of the battery power supervisor: valid, ready and one result word.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface bps_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_byte;
    logic [1:0] power_mode;
    logic       sys_enable;
    logic       motor_enable;
    logic       adc_start;
    logic       sleep_request;

    modport source (output valid, read_byte, power_mode, sys_enable, motor_enable,
                    adc_start, sleep_request, input ready);
    modport sink (input valid, read_byte, power_mode, sys_enable, motor_enable,
                  adc_start, sleep_request, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bps_button.sv =====
// Button debounce and press classification for one millisecond sample.
// Depends on bps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bps_button import bps_pkg::*; (
    input  wire logic        i_level,
    input  wire t_btn_state  i_state,
    input  wire t_mode       i_mode,
    input  wire logic [7:0]  i_shutdown,
    input  wire logic        i_sample_ok,
    input  wire logic [15:0] i_short_limit,
    input  wire logic [15:0] i_hold_limit,
    input  wire logic [7:0]  i_sd_delay,
    output t_btn_next        o_next
);

    logic [7:0]  hist;
    logic [15:0] press_inc;
    logic        act_short;
    logic        act_long;
    logic        act_off;
    t_phase      next_phase;
    logic [15:0] next_press;
    t_mode       next_mode;
    logic [7:0]  next_sd;

    assign hist      = {i_state.hist[6:0], i_level};
    assign press_inc = (i_state.press < PRESS_MAX) ? i_state.press + 16'd1 : i_state.press;

    // Classify the press and walk the phases
    always_comb begin
        act_short  = 1'b0;
        act_long   = 1'b0;
        act_off    = 1'b0;
        next_phase = i_state.phase;
        next_press = i_state.press;
        case (i_state.phase)
            PH_UP: begin
                if (hist[2:0] == 3'b000) begin
                    next_phase = PH_DOWN;
                    next_press = '0;
                end
            end
            PH_DOWN: begin
                next_press = press_inc;
                if (hist[3:0] == 4'hf) begin
                    if (press_inc < i_short_limit) begin
                        act_short = 1'b1;
                    end else if (press_inc < i_hold_limit) begin
                        act_long = 1'b1;
                    end else begin
                        act_off = 1'b1;
                    end
                    next_phase = PH_UP;
                end else if (press_inc > i_hold_limit) begin
                    act_off    = 1'b1;
                    next_phase = PH_LINGER;
                end
            end
            default: begin
                if (hist[3:0] == 4'hf) begin
                    next_phase = PH_UP;
                end
            end
        endcase
    end

    // Apply the press to the power mode
    always_comb begin
        next_mode = i_mode;
        next_sd   = i_shutdown;
        if (act_short) begin
            case (i_mode)
                MODE_OFF: begin
                    if (i_sample_ok) begin
                        next_mode = MODE_ON;
                    end
                end
                MODE_SYS: next_mode = MODE_ON;
                default:  next_mode = MODE_SYS;
            endcase
        end else if (act_long) begin
            if (i_mode != MODE_OFF) begin
                next_mode = MODE_SYS;
                next_sd   = i_sd_delay;
            end
        end else if (act_off) begin
            next_mode = MODE_OFF;
        end
    end

    assign o_next = '{hist: hist, phase: next_phase, press: next_press, mode: next_mode,
                      shutdown: next_sd, reload_sleep: (next_phase != PH_UP)};

endmodule

`default_nettype wire

// ===== rtl/core/bps_regread.sv =====
// Bus read multiplexer over the supervisor's visible registers.
// Depends on bps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bps_regread import bps_pkg::*; (
    input  wire logic [7:0] i_addr,
    input  wire t_reg_view  i_regs,
    output logic [7:0]      o_data
);

    // Select the addressed register, zero elsewhere
    always_comb begin
        case (i_addr)
            REG_MODE:     o_data = {6'd0, i_regs.mode};
            REG_SHUTDOWN: o_data = i_regs.shutdown;
            REG_LAST:     o_data = i_regs.last_sample[9:2];
            REG_CUTOFF:   o_data = i_regs.cutoff[9:2];
            REG_SLEEP:    o_data = {4'd0, i_regs.sleep};
            REG_SHIST:    o_data = i_regs.shist;
            default:      o_data = 8'd0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/battery_power_supervisor.sv =====
// Battery power supervisor top level: input register, update logic, result register.
// A word accepted into the input register passes the update logic into the result
// register once that is free; a stalled result holds the word in the input register.
// Throughput: one word per cycle while results are taken, set by the single pass of
// flat update logic; an empty input register takes a new word while a result waits.
// Reset (synchronous, active low) restores the configuration and state to their
// documented values and empties both registers at once; no clearing pass.
// Depends on bps_pkg, bps_in_if, bps_out_if, bps_button and bps_regread.
`timescale 1ns / 1ps
`default_nettype none

module battery_power_supervisor import bps_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    bps_in_if.sink           i_in,
    bps_out_if.source        o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);

    // Configuration
    logic [15:0] r_short_limit;
    logic [15:0] r_hold_limit;
    logic [7:0]  r_sd_delay;
    logic [3:0]  r_sleep_tmo;

    // Input register
    logic        r_in_valid;
    t_req        r_in_req;
    logic        r_in_level;
    logic [9:0]  r_in_adc;
    logic        r_in_rd;
    logic [7:0]  r_in_byte;

    // Supervisor state
    t_mode       r_mode,    n_mode;
    logic [7:0]  r_sd,      n_sd;
    logic [3:0]  r_sleep,   n_sleep;
    logic [9:0]  r_last,    n_last;
    logic [7:0]  r_shist,   n_shist;
    logic [9:0]  r_cutoff,  n_cutoff;
    logic [7:0]  r_bhist,   n_bhist;
    t_phase      r_phase,   n_phase;
    logic [15:0] r_press,   n_press;
    logic [7:0]  r_ptr,     n_ptr;
    logic        r_expect,  n_expect;

    // Result register
    logic        r_out_valid;
    logic [7:0]  r_rb,      n_rb;
    logic        r_start,   n_start;
    t_mode       r_out_mode;
    logic        r_sleep_req, n_sleep_req;

    logic        out_free;
    logic        in_ready;
    logic        fire;
    logic [7:0]  rd_data;
    logic [7:0]  shist_adc;
    t_btn_state  btn_state;
    t_btn_next   btn_next;
    t_reg_view   reg_view;

    assign out_free = !r_out_valid || o_out.ready;
    assign in_ready = !r_in_valid || out_free;
    assign fire     = r_in_valid && out_free;
    assign i_in.ready = in_ready;

    assign btn_state = '{hist: r_bhist, phase: r_phase, press: r_press};
    assign reg_view  = '{mode: r_mode, shutdown: r_sd, last_sample: r_last,
                         cutoff: r_cutoff, sleep: r_sleep, shist: r_shist};
    assign shist_adc = {r_shist[6:0], (r_in_adc >= r_cutoff)};

    bps_button u_button (
        .i_level       (r_in_level),
        .i_state       (btn_state),
        .i_mode        (r_mode),
        .i_shutdown    (r_sd),
        .i_sample_ok   (r_shist[0]),
        .i_short_limit (r_short_limit),
        .i_hold_limit  (r_hold_limit),
        .i_sd_delay    (r_sd_delay),
        .o_next        (btn_next)
    );

    bps_regread u_regread (
        .i_addr (r_ptr),
        .i_regs (reg_view),
        .o_data (rd_data)
    );

    // Work out the state after the word in the input register
    always_comb begin
        n_mode   = r_mode;
        n_sd     = r_sd;
        n_sleep  = r_sleep;
        n_last   = r_last;
        n_shist  = r_shist;
        n_cutoff = r_cutoff;
        n_bhist  = r_bhist;
        n_phase  = r_phase;
        n_press  = r_press;
        n_ptr    = r_ptr;
        n_expect = r_expect;
        n_rb     = 8'd0;
        n_start  = 1'b0;
        case (r_in_req)
            REQ_MS: begin
                n_bhist = btn_next.hist;
                n_phase = btn_next.phase;
                n_press = btn_next.press;
                n_mode  = btn_next.mode;
                n_sd    = btn_next.shutdown;
                if (btn_next.reload_sleep) begin
                    n_sleep = r_sleep_tmo;
                end
            end
            REQ_SLOW: begin
                n_start = 1'b1;
                if (r_mode == MODE_OFF && r_sleep != 4'd0) begin
                    n_sleep = r_sleep - 4'd1;
                end
                if (r_sd != 8'd0) begin
                    if (r_sd == 8'd1) begin
                        n_mode = MODE_OFF;
                        n_sd   = 8'd0;
                    end else if (r_sd > 8'd3) begin
                        n_sd = r_sd - 8'd2;
                    end else begin
                        n_sd = 8'd1;
                    end
                end
            end
            REQ_ADC: begin
                n_last  = r_in_adc;
                n_shist = shist_adc;
                if (r_mode != MODE_OFF && shist_adc[2:0] == 3'b000) begin
                    n_mode = MODE_SYS;
                    if (r_sd == 8'd0) begin
                        n_sd = r_sd_delay;
                    end
                end
            end
            REQ_WAKE: begin
                n_sleep = r_sleep_tmo;
            end
            REQ_START: begin
                if (!r_in_rd) begin
                    n_expect = 1'b1;
                end
            end
            REQ_DATA: begin
                if (r_in_rd) begin
                    n_rb  = rd_data;
                    n_ptr = r_ptr + 8'd1;
                end else if (r_expect) begin
                    n_ptr    = r_in_byte;
                    n_expect = 1'b0;
                end else begin
                    // ignore a mode write of an undefined code
                    if (r_ptr == REG_MODE) begin
                        if (r_in_byte <= 8'd2) begin
                            n_mode = t_mode'(r_in_byte[1:0]);
                        end
                    end else if (r_ptr == REG_SHUTDOWN) begin
                        n_sd = r_in_byte;
                    end else if (r_ptr == REG_CUTOFF) begin
                        n_cutoff = {r_in_byte, 2'b00};
                    end
                    n_ptr = r_ptr + 8'd1;
                end
            end
            default: begin
            end
        endcase
        n_sleep_req = (n_mode == MODE_OFF) && (n_sleep == 4'd0);
    end

    // Hold configuration, state and handshake flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_limit <= RST_SHORT_LIMIT;
            r_hold_limit  <= RST_HOLD_LIMIT;
            r_sd_delay    <= RST_SD_DELAY;
            r_sleep_tmo   <= RST_SLEEP_TMO;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_mode        <= MODE_OFF;
            r_sd          <= 8'd0;
            r_sleep       <= RST_SLEEP_TMO;
            r_last        <= 10'd0;
            r_shist       <= 8'hff;
            r_cutoff      <= RST_CUTOFF;
            r_bhist       <= 8'hff;
            r_phase       <= PH_UP;
            r_press       <= 16'd0;
            r_ptr         <= 8'd0;
            r_expect      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SHORT_LIMIT: r_short_limit <= i_cfg_data;
                    CFG_HOLD_LIMIT:  r_hold_limit  <= i_cfg_data;
                    CFG_SD_DELAY:    r_sd_delay    <= i_cfg_data[7:0];
                    CFG_SLEEP_TMO:   r_sleep_tmo   <= i_cfg_data[3:0];
                    default: begin
                    end
                endcase
            end
            if (in_ready) begin
                r_in_valid <= i_in.valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (fire) begin
                r_mode   <= n_mode;
                r_sd     <= n_sd;
                r_sleep  <= n_sleep;
                r_last   <= n_last;
                r_shist  <= n_shist;
                r_cutoff <= n_cutoff;
                r_bhist  <= n_bhist;
                r_phase  <= n_phase;
                r_press  <= n_press;
                r_ptr    <= n_ptr;
                r_expect <= n_expect;
            end
        end
    end

    // Capture the incoming word
    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_in_req   <= t_req'(i_in.req_type);
            r_in_level <= i_in.button_level;
            r_in_adc   <= i_in.adc_value;
            r_in_rd    <= i_in.bus_read;
            r_in_byte  <= i_in.bus_byte;
        end
    end

    // Load the result word
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_rb        <= n_rb;
            r_start     <= n_start;
            r_out_mode  <= n_mode;
            r_sleep_req <= n_sleep_req;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.read_byte     = r_rb;
    assign o_out.power_mode    = r_out_mode;
    assign o_out.sys_enable    = (r_out_mode != MODE_OFF);
    assign o_out.motor_enable  = (r_out_mode == MODE_ON);
    assign o_out.adc_start     = r_start;
    assign o_out.sleep_request = r_sleep_req;

    // A stalled word in the input register is kept
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_free) |=> r_in_valid)
        else $error("input word dropped while result stalled");

    // A sleep request only goes out with power off
    a_sleep_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.sleep_request) |-> !o_out.sys_enable)
        else $error("sleep request with power on");

    // A read byte only comes with a plain result that starts no conversion
    a_rb_no_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.adc_start) |-> (o_out.read_byte == 8'd0))
        else $error("read byte on a tick result");

    // The pointer moves only when a bus data word is processed
    a_ptr_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ptr != $past(r_ptr)) |-> $past(fire && r_in_req == REQ_DATA))
        else $error("register pointer moved without a bus data word");

endmodule

`default_nettype wire
